// ----- hdl/mfwe_pkg.sv -----
package mfwe_pkg;

	localparam int CHUNK_NIBBLES = 16;
	localparam int MAX_RESULTS = 3;
	localparam int PADDR_W = 4;

	localparam logic [63:0] FULL_F_CHUNK = ~64'd0 << (64 - 4 * CHUNK_NIBBLES);

	localparam logic [1:0] REG_START_MARKER   = 2'd0;
	localparam logic [1:0] REG_TRAILER_MARKER = 2'd1;
	localparam logic [1:0] REG_ASYNC_WORD     = 2'd2;

	localparam logic [15:0] START_MARKER_RST   = 16'hABBA;
	localparam logic [15:0] TRAILER_MARKER_RST = 16'hEBBE;
	localparam logic [31:0] ASYNC_WORD_RST     = 32'h8000_0000;

	typedef struct packed {
		logic       command;
		logic [3:0] nibble;
	} mfwe_in_t;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} mfwe_out_t;

	typedef struct packed {
		logic [15:0] start_marker;
		logic [15:0] trailer_marker;
		logic [31:0] async_word;
	} mfwe_cfg_t;

	typedef struct packed {
		logic [11:0] mw;
		logic [1:0]  mwc;
		logic [11:0] er;
		logic [1:0]  erc;
		logic [63:0] cb;
		logic [4:0]  cf;
		logic [63:0] h0;
		logic [63:0] h1;
		logic [1:0]  hcnt;
		logic        tp;
		logic [3:0]  toff;
	} mfwe_state_t;

	typedef struct packed {
		logic [1:0]        n;
		logic [2:0][31:0]  w;
	} mfwe_res_t;

	typedef struct packed {
		mfwe_state_t s;
		mfwe_res_t   r;
	} mfwe_ctx_t;

	function automatic mfwe_ctx_t emit(mfwe_ctx_t x, logic [63:0] c, mfwe_cfg_t cfg);
		mfwe_ctx_t o;
		logic [31:0] h;
		logic [31:0] w;
		o = x;
		h = c[63:32];
		w = {h[7:0], h[15:8], h[23:16], h[31:24]};
		if (c != FULL_F_CHUNK && w != 32'd0 && w != cfg.async_word && x.r.n < 2'd3) begin
			o.r.w[x.r.n] = w;
			o.r.n = x.r.n + 2'd1;
		end
		return o;
	endfunction

	function automatic mfwe_ctx_t flush_held(mfwe_ctx_t x, mfwe_cfg_t cfg);
		mfwe_ctx_t o;
		o = x;
		if (x.s.hcnt != 2'd0) o = emit(o, x.s.h0, cfg);
		if (x.s.hcnt >= 2'd2) o = emit(o, x.s.h1, cfg);
		o.s.hcnt = 2'd0;
		return o;
	endfunction

	function automatic mfwe_ctx_t settle(mfwe_ctx_t x, mfwe_cfg_t cfg);
		mfwe_ctx_t o;
		o = x;
		if (!x.s.tp) begin
			if (x.s.hcnt >= 2'd1 && x.s.hcnt <= 2'd2 && x.s.cf < 5'd3) begin
				if (x.s.hcnt == 2'd2) begin
					o = emit(o, x.s.h0, cfg);
					o.s.h0 = x.s.h1;
				end
				o.s.hcnt = 2'd1;
			end else begin
				o = flush_held(o, cfg);
			end
		end
		return o;
	endfunction

	function automatic mfwe_ctx_t push_nibble(mfwe_ctx_t x, logic [3:0] n, mfwe_cfg_t cfg);
		mfwe_ctx_t o;
		logic [3:0] f;
		logic [15:0] w16;
		logic occ;
		o = x;
		f = x.s.cf[3:0];
		w16 = {x.s.er, n};
		occ = (x.s.erc == 2'd3) && (w16 == cfg.trailer_marker);
		o.s.er = w16[11:0];
		if (x.s.erc != 2'd3) o.s.erc = x.s.erc + 2'd1;
		o.s.cb[6'd60 - {f, 2'b00} +: 4] = x.s.cb[6'd60 - {f, 2'b00} +: 4] | n;
		o.s.cf = {1'b0, f} + 5'd1;
		if (occ) begin
			if (f >= 4'd3) begin
				o = flush_held(o, cfg);
				o.s.toff = f - 4'd3;
			end else begin
				if (o.s.hcnt == 2'd2) begin
					o = emit(o, o.s.h0, cfg);
					o.s.h0 = o.s.h1;
					o.s.hcnt = 2'd1;
				end else if (o.s.hcnt != 2'd1) begin
					o = flush_held(o, cfg);
					o.s.h0 = 64'd0;
					o.s.hcnt = 2'd1;
				end
				o.s.toff = 4'(5'(CHUNK_NIBBLES) + {1'b0, f} - 5'd3);
			end
			o.s.tp = 1'b1;
		end else if (n != 4'd0) begin
			o.s.tp = 1'b0;
		end
		o = settle(o, cfg);
		if (o.s.cf >= 5'(CHUNK_NIBBLES)) begin
			if (o.s.hcnt >= 2'd2) begin
				o.s.hcnt = 2'd3;
			end else begin
				if (o.s.hcnt == 2'd0) o.s.h0 = o.s.cb;
				else o.s.h1 = o.s.cb;
				o.s.hcnt = o.s.hcnt + 2'd1;
			end
			o.s.cb = 64'd0;
			o.s.cf = 5'd0;
		end
		return o;
	endfunction

	function automatic mfwe_ctx_t end_entry(mfwe_ctx_t x, mfwe_cfg_t cfg);
		mfwe_ctx_t o;
		logic [63:0] c;
		logic [63:0] mask;
		o = x;
		c = (x.s.hcnt != 2'd0) ? x.s.h0 : x.s.cb;
		mask = ~64'd0 << (7'd64 - {1'b0, x.s.toff, 2'b00});
		if (x.s.tp) begin
			if (x.s.toff != 4'd0) o = emit(o, c & mask, cfg);
		end else begin
			o = flush_held(o, cfg);
			if (x.s.cf != 5'd0) o = emit(o, x.s.cb, cfg);
		end
		o.s.er = 12'd0;
		o.s.erc = 2'd0;
		o.s.cb = 64'd0;
		o.s.cf = 5'd0;
		o.s.hcnt = 2'd0;
		o.s.tp = 1'b0;
		o.s.toff = 4'd0;
		return o;
	endfunction

	function automatic mfwe_ctx_t step(mfwe_state_t s, logic cmd, logic [3:0] n, mfwe_cfg_t cfg);
		mfwe_ctx_t x;
		logic [15:0] w;
		x.s = s;
		x.r = '0;
		w = {s.mw, n};
		if (cmd) begin
			if (s.mwc == 2'd3) x = push_nibble(x, s.mw[11:8], cfg);
			if (s.mwc >= 2'd2) x = push_nibble(x, s.mw[7:4], cfg);
			if (s.mwc >= 2'd1) x = push_nibble(x, s.mw[3:0], cfg);
			x = end_entry(x, cfg);
			x.s.mw = 12'd0;
			x.s.mwc = 2'd0;
		end else if (s.mwc == 2'd3) begin
			if (w == cfg.start_marker) begin
				x = end_entry(x, cfg);
				x.s.mw = 12'd0;
				x.s.mwc = 2'd0;
			end else begin
				x = push_nibble(x, s.mw[11:8], cfg);
				x.s.mw = w[11:0];
			end
		end else begin
			x.s.mw = {s.mw[7:0], n};
			x.s.mwc = s.mwc + 2'd1;
		end
		return x;
	endfunction

endpackage

// ----- hdl/mfwe_proc.sv -----
module mfwe_proc import mfwe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  mfwe_in_t   item,
	input  mfwe_cfg_t  cfg,
	output mfwe_res_t  res
);

	mfwe_state_t st_q;
	mfwe_ctx_t   nxt;

	always_comb begin
		nxt = step(st_q, item.command, item.nibble, cfg);
	end

	assign res = nxt.r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (go) begin
			st_q <= nxt.s;
		end
	end

`ifndef SYNTHESIS
	a_fill_below_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.cf < 5'(CHUNK_NIBBLES))
		else $error("chunk fill reached chunk size at rest");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		go && item.command |=> st_q.mwc == 2'd0 && st_q.cf == 5'd0 && st_q.hcnt == 2'd0
			&& !st_q.tp && st_q.erc == 2'd0)
		else $error("end of stream left state behind");
`endif

endmodule

// ----- hdl/marker_framed_word_extractor_core.sv -----
// Nibble stream to word extractor. One item is taken per clock while the result buffer can
// take its results; an item is registered, then its marker, trailer and chunk logic runs
// combinationally and its results (up to three) land in a three-word result buffer that
// is registered behind the input register. An item with several results holds off the
// next item's processing, since the buffer takes new results only when it is empty or
// its single remaining word is leaving. Registers: start marker at 0x0, trailer marker at
// 0x4, async word at 0x8; write them only while the block is idle.
module marker_framed_word_extractor_core import mfwe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mfwe_in_t           in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output mfwe_out_t          out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	mfwe_cfg_t cfg_q;
	logic      vld_s1;
	mfwe_in_t  item_s1;
	logic      go;
	mfwe_res_t res;
	logic [2:0][31:0] rb_q;
	logic [1:0] rcnt_q;
	logic       pop;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker <= START_MARKER_RST;
			cfg_q.trailer_marker <= TRAILER_MARKER_RST;
			cfg_q.async_word <= ASYNC_WORD_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_START_MARKER:   cfg_q.start_marker <= pwdata[15:0];
				REG_TRAILER_MARKER: cfg_q.trailer_marker <= pwdata[15:0];
				REG_ASYNC_WORD:     cfg_q.async_word <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_START_MARKER:   prdata = {16'd0, cfg_q.start_marker};
			REG_TRAILER_MARKER: prdata = {16'd0, cfg_q.trailer_marker};
			REG_ASYNC_WORD:     prdata = cfg_q.async_word;
			default:            prdata = 32'd0;
		endcase
	end

	assign pop = out_valid && out_ready;
	assign go = vld_s1 && (rcnt_q == 2'd0 || (rcnt_q == 2'd1 && out_ready));
	assign in_ready = !vld_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (go) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	mfwe_proc u_proc (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= 2'd0;
		end else if (go) begin
			rcnt_q <= res.n;
		end else if (pop) begin
			rcnt_q <= rcnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rb_q <= res.w;
		end else if (pop) begin
			rb_q[0] <= rb_q[1];
			rb_q[1] <= rb_q[2];
		end
	end

	assign out_valid = rcnt_q != 2'd0;
	assign out_data.word = rb_q[0];
	assign out_data.last = rcnt_q == 2'd1;

`ifndef SYNTHESIS
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !go |=> vld_s1 && $stable(item_s1))
		else $error("stalled item changed in input register");

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last |=> out_valid)
		else $error("item results ended without last");

	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		go && res.n != 2'd0 |=> out_valid && rcnt_q == $past(res.n))
		else $error("result buffer lost results");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import mfwe_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 100;

	typedef struct packed {
		logic        cmd;
		logic [3:0]  nib;
		logic        fix;
		logic        one;
		logic [31:0] w0;
	} dir_row_t;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	mfwe_in_t           in_data   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	mfwe_out_t          out_data;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [31:0]        pwdata    = '0;
	logic [31:0]        prdata;
	logic               pready;

	marker_framed_word_extractor_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// extractor state as seen by the predictor
	logic [15:0] cur_start   = START_MARKER_RST;
	logic [15:0] cur_trailer = TRAILER_MARKER_RST;
	logic [31:0] cur_async   = ASYNC_WORD_RST;
	logic [11:0] mk_win      = '0;
	logic [1:0]  mk_cnt      = '0;
	logic [11:0] tail_nib    = '0;
	logic [1:0]  tail_cnt    = '0;
	logic [63:0] chunk_acc   = '0;
	logic [4:0]  chunk_len   = '0;
	logic [63:0] hold [0:1]  = '{64'd0, 64'd0};
	logic [1:0]  hold_n      = '0;
	logic        trl_armed   = 1'b0;
	logic [3:0]  trl_pos     = '0;

	logic [31:0] step_words[$];
	mfwe_out_t   pending_words[$];
	mfwe_in_t    plan[$];

	int fail_cnt    = 0;
	int quiet_cycles = 0;
	int burst_left  = 0;
	int rx_mode     = 0;
	int rx_period   = 2;
	int rx_duty     = 1;
	int rx_phase    = 0;
	int rx_left     = 0;
	mfwe_out_t head;

	function automatic void keep_word(logic [63:0] c);
		logic [31:0] h;
		logic [31:0] w;
		h = c[63:32];
		w = {h[7:0], h[15:8], h[23:16], h[31:24]};
		if (c != FULL_F_CHUNK && w != 32'd0 && w != cur_async && step_words.size() < MAX_RESULTS)
			step_words.insert(step_words.size(), w);
	endfunction

	function automatic void drain_hold();
		if (hold_n != 2'd0) keep_word(hold[0]);
		if (hold_n >= 2'd2) keep_word(hold[1]);
		hold_n = 2'd0;
	endfunction

	function automatic void feed_nibble(logic [3:0] n);
		logic [3:0]  f;
		logic [15:0] w16;
		logic        hit;
		f = chunk_len[3:0];
		w16 = {tail_nib, n};
		hit = (tail_cnt == 2'd3) && (w16 == cur_trailer);
		tail_nib = w16[11:0];
		if (tail_cnt != 2'd3) tail_cnt = tail_cnt + 2'd1;
		chunk_acc = chunk_acc | (64'(n) << (60 - 4 * f));
		chunk_len = 5'(f) + 5'd1;
		if (hit) begin
			if (f >= 4'd3) begin
				drain_hold();
				trl_pos = f - 4'd3;
			end else begin
				if (hold_n == 2'd2) begin
					keep_word(hold[0]);
					hold[0] = hold[1];
					hold_n = 2'd1;
				end else if (hold_n != 2'd1) begin
					drain_hold();
					hold[0] = 64'd0;
					hold_n = 2'd1;
				end
				trl_pos = 4'(CHUNK_NIBBLES + f - 3);
			end
			trl_armed = 1'b1;
		end else if (n != 4'd0) begin
			trl_armed = 1'b0;
		end
		// release held chunks once no trailer can reach back into them
		if (!trl_armed) begin
			if (hold_n >= 2'd1 && hold_n <= 2'd2 && chunk_len < 5'd3) begin
				if (hold_n == 2'd2) begin
					keep_word(hold[0]);
					hold[0] = hold[1];
				end
				hold_n = 2'd1;
			end else begin
				drain_hold();
			end
		end
		if (chunk_len >= 5'(CHUNK_NIBBLES)) begin
			if (hold_n >= 2'd2) begin
				hold_n = 2'd3;
			end else begin
				hold[hold_n[0]] = chunk_acc;
				hold_n = hold_n + 2'd1;
			end
			chunk_acc = 64'd0;
			chunk_len = 5'd0;
		end
	endfunction

	function automatic void close_entry();
		logic [63:0] c;
		if (trl_armed) begin
			c = (hold_n != 2'd0) ? hold[0] : chunk_acc;
			if (trl_pos != 4'd0) keep_word(c & (~64'd0 << (64 - 4 * trl_pos)));
		end else begin
			drain_hold();
			if (chunk_len != 5'd0) keep_word(chunk_acc);
		end
		tail_nib = '0;
		tail_cnt = '0;
		chunk_acc = '0;
		chunk_len = '0;
		hold_n = '0;
		trl_armed = 1'b0;
		trl_pos = '0;
	endfunction

	function automatic void advance_extractor(mfwe_in_t it);
		logic [15:0] w;
		step_words.delete();
		w = {mk_win, it.nibble};
		if (it.command) begin
			if (mk_cnt == 2'd3) feed_nibble(mk_win[11:8]);
			if (mk_cnt >= 2'd2) feed_nibble(mk_win[7:4]);
			if (mk_cnt >= 2'd1) feed_nibble(mk_win[3:0]);
			close_entry();
			mk_win = '0;
			mk_cnt = '0;
		end else if (mk_cnt == 2'd3) begin
			if (w == cur_start) begin
				close_entry();
				mk_win = '0;
				mk_cnt = '0;
			end else begin
				feed_nibble(mk_win[11:8]);
				mk_win = w[11:0];
			end
		end else begin
			mk_win = w[11:0];
			mk_cnt = mk_cnt + 2'd1;
		end
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_item(input mfwe_in_t it, input logic fix, input logic one,
			input logic [31:0] w0);
		mfwe_out_t r;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
		end
		in_data <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		advance_extractor(it);
		if (fix) begin
			if (one) begin
				r.word = w0;
				r.last = 1'b1;
				pending_words.insert(pending_words.size(), r);
			end
		end else begin
			for (int i = 0; i < step_words.size(); i++) begin
				r.word = step_words[i];
				r.last = (i == step_words.size() - 1);
				pending_words.insert(pending_words.size(), r);
			end
		end
		burst_left--;
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_START_MARKER:   cur_start = val[15:0];
			REG_TRAILER_MARKER: cur_trailer = val[15:0];
			REG_ASYNC_WORD:     cur_async = val;
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	function automatic void add_nib(logic [3:0] n);
		mfwe_in_t x;
		x.command = 1'b0;
		x.nibble = n;
		plan.insert(plan.size(), x);
	endfunction

	function automatic void add_end();
		mfwe_in_t x;
		x.command = 1'b1;
		x.nibble = 4'($urandom_range(0, 15));
		plan.insert(plan.size(), x);
	endfunction

	function automatic void add_zeros(int len);
		repeat (len) add_nib(4'd0);
	endfunction

	function automatic void add_marker(logic [15:0] m, int cnt);
		for (int i = 3; i > 3 - cnt; i--) add_nib(m[4*i +: 4]);
	endfunction

	// one entry framed by the start marker, a stretch of noise, or end commands
	function automatic void build_piece();
		int r;
		int len;
		int body;
		logic [31:0] aw;
		plan.delete();
		r = $urandom_range(0, 9);
		if (r <= 5) begin
			add_marker(cur_start, 4);
			body = 0;
			repeat ($urandom_range(0, 4)) begin
				case ($urandom_range(0, 5))
					0: begin
						len = $urandom_range(1, 20);
						repeat (len) add_nib(4'($urandom_range(0, 15)));
						body += len;
					end
					1: begin
						len = $urandom_range(1, 20);
						add_zeros(len);
						body += len;
					end
					2: begin
						len = $urandom_range(0, 12);
						add_marker(cur_trailer, 4);
						add_zeros(len);
						body += 4 + len;
					end
					3: begin
						while (body % CHUNK_NIBBLES != 0) begin
							add_nib(4'($urandom_range(1, 14)));
							body++;
						end
						repeat (CHUNK_NIBBLES) add_nib(4'hF);
						body += CHUNK_NIBBLES;
					end
					4: begin
						while (body % CHUNK_NIBBLES != 0) begin
							add_nib(4'($urandom_range(1, 14)));
							body++;
						end
						aw = ($urandom_range(0, 3) == 0) ? $urandom : cur_async;
						for (int i = 0; i < 4; i++) begin
							add_nib(aw[8*i+4 +: 4]);
							add_nib(aw[8*i +: 4]);
						end
						len = $urandom_range(0, 8);
						repeat (len) add_nib(4'($urandom_range(0, 15)));
						body += 8 + len;
					end
					default: begin
						len = $urandom_range(0, 5);
						add_marker(cur_trailer, 4);
						add_zeros(len);
						add_nib(4'($urandom_range(1, 15)));
						body += 5 + len;
					end
				endcase
			end
			if ($urandom_range(0, 1)) add_end();
		end else if (r <= 8) begin
			if ($urandom_range(0, 1)) add_marker(cur_start, $urandom_range(1, 3));
			repeat ($urandom_range(1, 12)) add_nib(4'($urandom_range(0, 15)));
			if ($urandom_range(0, 2) == 0) begin
				add_marker(cur_trailer, 4);
				add_zeros($urandom_range(0, 4));
				add_nib(4'($urandom_range(1, 15)));
			end
		end else begin
			add_end();
			if ($urandom_range(0, 1)) add_end();
		end
	endfunction

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_period = $urandom_range(2, 9);
			rx_duty = $urandom_range(1, rx_period - 1);
			rx_left = $urandom_range(50, 300);
		end
		rx_left--;
		rx_phase = (rx_phase + 1) % rx_period;
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= (rx_phase >= rx_duty);
			default: out_ready <= 1'($urandom_range(0, 1));
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$error("unexpected item: word %h last %b", out_data.word, out_data.last);
				fail_cnt++;
			end else begin
				head = pending_words.pop_front();
				if (out_data.word !== head.word) begin
					$error("word: expected %h, got %h", head.word, out_data.word);
					fail_cnt++;
				end
				if (out_data.last !== head.last) begin
					$error("last: expected %b, got %b", head.last, out_data.last);
					fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		dir_row_t dir_tab [25];
		mfwe_in_t it;
		int sent;
		logic [15:0] sm;
		logic [15:0] tm;
		logic [31:0] aw;
		dir_tab = '{
			'{1'b1, 4'h0, 1'b1, 1'b0, 32'h0},
			'{1'b0, 4'hF, 1'b0, 1'b0, 32'h0},
			'{1'b0, 4'hF, 1'b0, 1'b0, 32'h0},
			'{1'b0, 4'hF, 1'b0, 1'b0, 32'h0},
			'{1'b0, 4'hF, 1'b0, 1'b0, 32'h0},
			'{1'b0, 4'hF, 1'b0, 1'b0, 32'h0},
			'{1'b0, 4'hF, 1'b0, 1'b0, 32'h0},
			'{1'b0, 4'hF, 1'b0, 1'b0, 32'h0},
			'{1'b0, 4'hF, 1'b0, 1'b0, 32'h0},
			'{1'b1, 4'hF, 1'b1, 1'b1, 32'hFFFF_FFFF},
			'{1'b0, 4'h9, 1'b0, 1'b0, 32'h0},
			'{1'b0, 4'hA, 1'b0, 1'b0, 32'h0},
			'{1'b0, 4'hB, 1'b0, 1'b0, 32'h0},
			'{1'b0, 4'hB, 1'b0, 1'b0, 32'h0},
			'{1'b0, 4'hA, 1'b1, 1'b1, 32'h0000_0090},
			'{1'b0, 4'h3, 1'b0, 1'b0, 32'h0},
			'{1'b1, 4'h0, 1'b1, 1'b1, 32'h0000_0030},
			'{1'b0, 4'h5, 1'b0, 1'b0, 32'h0},
			'{1'b0, 4'hE, 1'b0, 1'b0, 32'h0},
			'{1'b0, 4'hB, 1'b0, 1'b0, 32'h0},
			'{1'b0, 4'hB, 1'b0, 1'b0, 32'h0},
			'{1'b0, 4'hE, 1'b0, 1'b0, 32'h0},
			'{1'b0, 4'h0, 1'b0, 1'b0, 32'h0},
			'{1'b0, 4'h0, 1'b0, 1'b0, 32'h0},
			'{1'b1, 4'h0, 1'b1, 1'b1, 32'h0000_0050}
		};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			it.command = dir_tab[i].cmd;
			it.nibble = dir_tab[i].nib;
			send_item(it, dir_tab[i].fix, dir_tab[i].one, dir_tab[i].w0);
		end

		for (int ph = 0; ph < 5; ph++) begin
			if (ph != 0) begin
				case (ph)
					1: begin sm = 16'h0000; tm = 16'hFFFF; aw = 32'hFFFF_FFFF; end
					2: begin sm = 16'hFFFF; tm = 16'h0000; aw = 32'h0000_0000; end
					3: begin sm = 16'($urandom); tm = 16'($urandom); aw = $urandom; end
					default: begin sm = START_MARKER_RST; tm = TRAILER_MARKER_RST; aw = $urandom; end
				endcase
				drain_results();
				cfg_write(REG_START_MARKER, {16'd0, sm});
				cfg_write(REG_TRAILER_MARKER, {16'd0, tm});
				cfg_write(REG_ASYNC_WORD, aw);
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				build_piece();
				foreach (plan[i]) send_item(plan[i], 1'b0, 1'b0, 32'd0);
				sent += plan.size();
			end
		end

		drain_results();
		if (fail_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
